// ----- design/mbe_pkg.sv -----
// shared types and constants for the mandelbrot escape-time block
package mbe_pkg;

  localparam int FRAC_BITS = 28;
  localparam int POINT_W   = 31;
  localparam int ITER_W    = 8;
  localparam int COLOR_W   = 3;
  localparam int ZW        = 33;
  localparam int PW        = 2 * ZW;
  localparam int SUM_W     = PW + 1;

  localparam logic [SUM_W-1:0] ESC_LIMIT = SUM_W'(1) << (2 * FRAC_BITS + 2);

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 16;

  localparam int                 PADDR_W       = 3;
  localparam int                 PDATA_W       = 32;
  localparam logic [PADDR_W-1:0] ADDR_MAX_ITER = 3'd0;
  localparam logic [ITER_W-1:0]  MAX_ITER_RST  = 8'd100;

  typedef struct packed {
    logic signed [POINT_W-1:0] re;
    logic signed [POINT_W-1:0] im;
    logic [ITER_W-1:0]         limit;
  } job_t;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_MUL,
    CORE_EVAL,
    CORE_FLUSH
  } core_state_e;

endpackage

// ----- design/mandelbrot_escape_time_top.sv -----
// Mandelbrot escape-time evaluator: one point in, one escape count and palette index out.
// Points enter through a one-entry input stage into a short job queue, each job tagged
// with max_iterations as it was when the point was taken. The core handles one point at
// a time: every iteration has a product step for the three 33x33 products of z and an
// evaluate step for the escape test and the z*z + c update. The result sits in an output
// register while the core goes on with the next queued point.
module mandelbrot_escape_time_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mbe_pkg::PADDR_W-1:0]     paddr,
  input  logic [mbe_pkg::PDATA_W-1:0]     pwdata,
  output logic [mbe_pkg::PDATA_W-1:0]     prdata,
  output logic                            pready,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // point_re [30:0], point_im [61:31], zero pad [63:62]
  input  logic [mbe_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // escape_count [7:0], color_index [10:8], zero pad [15:11]
  output logic [mbe_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import mbe_pkg::*;

  logic              push, full, pop, job_valid;
  job_t              front_job, queue_job;
  logic [ITER_W-1:0] escape_count;
  logic [COLOR_W-1:0] color_index;

  mbe_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .push_o        (push),
    .job_o         (front_job),
    .full_i        (full)
  );

  mbe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .job_o   (queue_job)
  );

  mbe_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (job_valid),
    .job_i          (queue_job),
    .pop_o          (pop),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .escape_count_o (escape_count),
    .color_index_o  (color_index)
  );

  assign m_axis_tdata = OUT_TDATA_W'({color_index, escape_count});

endmodule

// ----- design/mbe_front.sv -----
// front end: register port, input stage and job tagging with the iteration limit
module mbe_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mbe_pkg::PADDR_W-1:0]  paddr,
  input  logic [mbe_pkg::PDATA_W-1:0]  pwdata,
  output logic [mbe_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // point_re [30:0], point_im [61:31], zero pad [63:62]
  input  logic [mbe_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  output logic                         push_o,
  output mbe_pkg::job_t                job_o,
  input  logic                         full_i
);
  import mbe_pkg::*;

  logic [ITER_W-1:0] max_iter_q, max_iter_d;
  logic              slot_valid_q, slot_valid_d;
  job_t              slot_q, slot_d;
  logic              cfg_wr;
  logic              in_xfer;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = (paddr == ADDR_MAX_ITER) ? PDATA_W'(max_iter_q) : '0;

  assign push_o        = slot_valid_q && !full_i;
  assign s_axis_tready = !slot_valid_q || push_o;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign job_o         = slot_q;

  always_comb begin
    max_iter_d   = max_iter_q;
    slot_valid_d = slot_valid_q;
    slot_d       = slot_q;
    if (cfg_wr && (paddr == ADDR_MAX_ITER)) begin
      max_iter_d = pwdata[ITER_W-1:0];
    end
    if (in_xfer) begin
      slot_valid_d = 1'b1;
      slot_d.re    = s_axis_tdata[POINT_W-1:0];
      slot_d.im    = s_axis_tdata[2*POINT_W-1:POINT_W];
      slot_d.limit = max_iter_q;
    end else if (push_o) begin
      slot_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_iter_q   <= MAX_ITER_RST;
      slot_valid_q <= 1'b0;
    end else begin
      max_iter_q   <= max_iter_d;
      slot_valid_q <= slot_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

// ----- design/mbe_queue.sv -----
// small job queue between the front end and the iteration core
module mbe_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mbe_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output mbe_pkg::job_t job_o
);
  import mbe_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + CNT_W'(1);
        2'b01:   count_q <= count_q - CNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= job_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |-> (count_q != CNT_W'(DEPTH)))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> (count_q != '0))
    else $error("queue read while empty");

endmodule

// ----- design/mbe_core.sv -----
// iteration core: z = z*z + c with registered products and an escape test
module mbe_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          job_valid_i,
  input  mbe_pkg::job_t                 job_i,
  output logic                          pop_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [mbe_pkg::ITER_W-1:0]    escape_count_o,
  output logic [mbe_pkg::COLOR_W-1:0]   color_index_o
);
  import mbe_pkg::*;

  core_state_e state_q, state_d;
  logic [ITER_W-1:0] k_q, k_d, lim_q, lim_d, count_q, count_d;
  logic out_valid_q, out_valid_d;
  logic [ITER_W-1:0] out_count_q, out_count_d;

  logic signed [POINT_W-1:0] cre_q, cre_d, cim_q, cim_d;
  logic signed [ZW-1:0]      re_q, re_d, im_q, im_d;
  logic signed [PW-1:0]      sr_q, sr_d, si_q, si_d, cr_q, cr_d;

  logic [SUM_W-1:0]     mag_sum;
  logic                 escaped;
  logic signed [PW-1:0] diff;
  logic signed [ZW-1:0] re_next, im_next;
  logic                 load_out;

  assign mag_sum = SUM_W'($unsigned(sr_q)) + SUM_W'($unsigned(si_q));
  assign escaped = (k_q != '0) && (mag_sum > ESC_LIMIT);
  assign diff    = sr_q - si_q;
  assign re_next = ZW'(diff >>> FRAC_BITS) + ZW'(cre_q);
  assign im_next = ZW'(cr_q >>> (FRAC_BITS - 1)) + ZW'(cim_q);

  assign pop_o          = (state_q == CORE_IDLE) && job_valid_i;
  assign load_out       = (state_q == CORE_FLUSH) && (!out_valid_q || m_axis_tready);
  assign m_axis_tvalid  = out_valid_q;
  assign escape_count_o = out_count_q;
  assign color_index_o  = out_count_q[COLOR_W-1:0];

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    lim_d       = lim_q;
    count_d     = count_q;
    cre_d       = cre_q;
    cim_d       = cim_q;
    re_d        = re_q;
    im_d        = im_q;
    sr_d        = sr_q;
    si_d        = si_q;
    cr_d        = cr_q;
    out_count_d = out_count_q;
    out_valid_d = out_valid_q && !m_axis_tready;

    unique case (state_q)
      CORE_IDLE: begin
        if (job_valid_i) begin
          cre_d   = job_i.re;
          cim_d   = job_i.im;
          lim_d   = job_i.limit;
          re_d    = '0;
          im_d    = '0;
          k_d     = '0;
          state_d = CORE_MUL;
        end
      end
      CORE_MUL: begin
        sr_d    = re_q * re_q;
        si_d    = im_q * im_q;
        cr_d    = re_q * im_q;
        state_d = CORE_EVAL;
      end
      CORE_EVAL: begin
        priority if (escaped) begin
          count_d = k_q - ITER_W'(1);
          state_d = CORE_FLUSH;
        end else if (k_q == lim_q) begin
          count_d = lim_q;
          state_d = CORE_FLUSH;
        end else begin
          re_d    = re_next;
          im_d    = im_next;
          k_d     = k_q + ITER_W'(1);
          state_d = CORE_MUL;
        end
      end
      CORE_FLUSH: begin
        if (load_out) begin
          out_count_d = count_q;
          out_valid_d = 1'b1;
          state_d     = CORE_IDLE;
        end
      end
      default: state_d = CORE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CORE_IDLE;
      k_q         <= '0;
      lim_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      lim_q       <= lim_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    count_q     <= count_d;
    out_count_q <= out_count_d;
    cre_q       <= cre_d;
    cim_q       <= cim_d;
    re_q        <= re_d;
    im_q        <= im_d;
    sr_q        <= sr_d;
    si_q        <= si_d;
    cr_q        <= cr_d;
  end

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != CORE_IDLE) |-> (k_q <= lim_q))
    else $error("iteration index past limit");

  a_mul_then_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CORE_MUL) |=> (state_q == CORE_EVAL))
    else $error("product stage not followed by update");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (count_q <= lim_q))
    else $error("result count above limit");

endmodule

// ----- bench/tb_top.sv -----
// self-checking bench for the mandelbrot escape-time block: stream and apb stimulus, scoreboard
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mbe_pkg::*;

  localparam int  RST_CYCLES   = 4;
  localparam int  IDLE_PCT     = 11;
  localparam int  HOLD_AT      = 200;
  localparam int  HOLD_CYCLES  = 4000;
  localparam int  TAIL_CYCLES  = 600;
  localparam longint MAX_CYCLES = 2000000;

  localparam logic signed [POINT_W-1:0] PT_TWO     = 31'sd536870912;
  localparam logic signed [POINT_W-1:0] PT_NEG_TWO = -31'sd536870912;
  localparam logic signed [POINT_W-1:0] PT_MAX     = 31'sh3FFFFFFF;
  localparam logic signed [POINT_W-1:0] PT_MIN     = 31'sh40000000;
  localparam logic signed [POINT_W-1:0] PT_ONE     = 31'sd268435456;

  typedef struct packed {
    logic signed [POINT_W-1:0] re;
    logic signed [POINT_W-1:0] im;
  } point_t;

  typedef struct packed {
    logic [ITER_W-1:0]  count;
    logic [COLOR_W-1:0] color;
  } escape_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   psel    = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite  = 1'b0;
  logic [PADDR_W-1:0]     paddr   = '0;
  logic [PDATA_W-1:0]     pwdata  = '0;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // point_re [30:0], point_im [61:31], zero pad [63:62]
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // escape_count [7:0], color_index [10:8], zero pad [15:11]
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  point_t  points_to_send[$];
  escape_t expected_escapes[$];

  logic [ITER_W-1:0] iter_limit = MAX_ITER_RST;
  logic   calm       = 1'b0;
  int     errors     = 0;
  int     in_count   = 0;
  int     hold_left  = 0;
  logic   hold_done  = 1'b0;
  longint cycles     = 0;

  mandelbrot_escape_time_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  function automatic escape_t escape_time(logic signed [POINT_W-1:0] c_re,
                                          logic signed [POINT_W-1:0] c_im,
                                          logic [ITER_W-1:0] limit);
    logic signed [127:0] zr, zi, nr, ni, cr, ci, four;
    logic [ITER_W-1:0]   count;
    logic                escaped;
    int                  i;
    escape_t             res;
    cr      = c_re;
    ci      = c_im;
    zr      = '0;
    zi      = '0;
    four    = 128'sd1 <<< (2 * FRAC_BITS + 2);
    count   = limit;
    escaped = 1'b0;
    for (i = 0; i < int'(limit) && !escaped; i++) begin
      nr = ((zr * zr - zi * zi) >>> FRAC_BITS) + cr;
      ni = (((zr * zi) <<< 1) >>> FRAC_BITS) + ci;
      if (nr * nr + ni * ni > four) begin
        count   = ITER_W'(i);
        escaped = 1'b1;
      end else begin
        zr = nr;
        zi = ni;
      end
    end
    res.count = count;
    res.color = count[COLOR_W-1:0];
    return res;
  endfunction

  function automatic point_t random_point();
    point_t p;
    int     kind;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      // full 31-bit patterns, mostly outside the plane window
      p.re = POINT_W'($urandom);
      p.im = POINT_W'($urandom);
    end else if (kind < 8) begin
      p.re = POINT_W'(int'($urandom_range(0, 1073741824)) - 536870912);
      p.im = POINT_W'(int'($urandom_range(0, 1073741824)) - 536870912);
    end else begin
      // slow escapes near the boundary
      p.re = POINT_W'(-int'($urandom_range(187904819, 214748365)));
      p.im = POINT_W'(int'($urandom_range(0, 53687091)));
      if ($urandom_range(0, 1) == 1) p.im = -p.im;
    end
    return p;
  endfunction

  // stream driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (points_to_send.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        point_t p;
        p = points_to_send.pop_front();
        s_axis_tdata  <= {2'b00, p.im, p.re};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result receiver with one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (!hold_done && in_count >= HOLD_AT) begin
      hold_done     <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // monitor: predict on input transfer, check on output transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_escapes.push_back(escape_time($signed(s_axis_tdata[POINT_W-1:0]),
                                               $signed(s_axis_tdata[2*POINT_W-1:POINT_W]),
                                               iter_limit));
        in_count <= in_count + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_escapes.size() == 0) begin
          $error("unexpected result transfer, tdata %h", m_axis_tdata);
          errors++;
        end else begin
          escape_t want;
          want = expected_escapes.pop_front();
          if (m_axis_tdata[ITER_W-1:0] !== want.count) begin
            $error("escape_count expected %0d actual %0d", want.count,
                   m_axis_tdata[ITER_W-1:0]);
            errors++;
          end
          if (m_axis_tdata[ITER_W+COLOR_W-1:ITER_W] !== want.color) begin
            $error("color_index expected %0d actual %0d", want.color,
                   m_axis_tdata[ITER_W+COLOR_W-1:ITER_W]);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_MAX_ITER) iter_limit = data[ITER_W-1:0];
  endtask

  task automatic apb_check_limit();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_MAX_ITER;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata[ITER_W-1:0] !== iter_limit) begin
      $error("max_iterations expected %0d actual %0d", iter_limit, prdata[ITER_W-1:0]);
      errors++;
    end
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (points_to_send.size() != 0 || s_axis_tvalid || expected_escapes.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic send_point(input logic signed [POINT_W-1:0] re,
                            input logic signed [POINT_W-1:0] im);
    point_t p;
    p.re = re;
    p.im = im;
    points_to_send.push_back(p);
  endtask

  task automatic run_random(input logic [ITER_W-1:0] limit, input int n, input logic quiet);
    int k;
    apb_write(ADDR_MAX_ITER, PDATA_W'(limit));
    apb_check_limit();
    @(negedge clk_i);
    calm = quiet;
    for (k = 0; k < n; k++) points_to_send.push_back(random_point());
    wait_drained();
    calm = 1'b0;
  endtask

  initial begin
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    apb_check_limit();
    @(negedge clk_i);

    // corners at the reset limit
    send_point('0, '0);
    send_point(PT_TWO, '0);
    send_point(PT_NEG_TWO, '0);
    send_point('0, PT_TWO);
    send_point('0, PT_NEG_TWO);
    send_point(PT_TWO, PT_TWO);
    send_point(PT_NEG_TWO, PT_NEG_TWO);
    send_point(PT_MAX, PT_MAX);
    send_point(PT_MIN, PT_MIN);
    send_point(PT_MAX, PT_MIN);
    send_point(-PT_ONE, '0);
    send_point('0, PT_ONE);
    send_point(31'sd67108864, '0);
    send_point(31'sd69793218, '0);
    send_point(-31'sd1, -31'sd1);
    send_point(31'sh2AAAAAAA, 31'sh55555555);
    send_point(-31'sd201326592, 31'sd26843546);
    wait_drained();

    run_random(8'd255, 100, 1'b0);
    run_random(8'd0,    60, 1'b0);
    run_random(8'd1,    80, 1'b0);
    run_random(8'd2,    80, 1'b0);
    run_random(8'd8,   100, 1'b0);
    run_random(ITER_W'($urandom_range(3, 254)), 110, 1'b0);
    run_random(8'd64,  120, 1'b1);
    run_random(8'd255,  60, 1'b0);
    run_random(ITER_W'($urandom_range(1, 255)), 110, 1'b0);
    run_random(8'd100, 100, 1'b0);

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
